FILE: design/mts_pkg.sv
package mts_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
  localparam int COUNT_W     = 11;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [PTR_W-1:0]         ptr_t;
  typedef logic [COUNT_W-1:0]       count_t;

  localparam data_t NONE_VALUE = -32'sd1;
  localparam ptr_t  FULL_PTR   = ptr_t'(STACK_DEPTH);

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_POP_RD = 1'b1
  } state_t;

endpackage

FILE: design/mts_ram.sv
module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/min_tracking_stack.sv
// Channel  Ports                                   Handshake
// in       in_cmd, in_value                        start & !busy
// out      out_top_value, out_min_value,           out_valid, one cycle
//          out_is_empty, out_entry_count, out_overflow
//
// Push, peek and a pop on an empty stack strobe their result in the cycle
// after the item.
// Pop of a held value goes via ST_POP_RD: one synchronous read of each memory
// refills the top-of-stack registers; busy is high during the read cycle.
// Reset clears both pointers; memory contents are not cleared.
// The receiver cannot stall; results are never held back.
module min_tracking_stack (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_cmd,
  input  logic signed [31:0]             in_value,
  output logic                           out_valid,
  output logic signed [31:0]             out_top_value,
  output logic signed [31:0]             out_min_value,
  output logic                           out_is_empty,
  output logic [mts_pkg::COUNT_W-1:0]    out_entry_count,
  output logic                           out_overflow
);

  mts_pkg::state_t state_r, state_nxt;
  mts_pkg::ptr_t   vp_r, vp_nxt;
  mts_pkg::ptr_t   mp_r, mp_nxt;
  mts_pkg::data_t  top_r, top_nxt;
  mts_pkg::data_t  mtop_r, mtop_nxt;

  logic            out_valid_r, out_valid_nxt;
  mts_pkg::data_t  out_top_r, out_top_nxt;
  mts_pkg::data_t  out_min_r, out_min_nxt;
  logic            out_empty_r, out_empty_nxt;
  mts_pkg::count_t out_count_r, out_count_nxt;
  logic            out_ovf_r, out_ovf_nxt;

  logic            val_we, min_we;
  mts_pkg::addr_t  val_waddr, min_waddr;
  mts_pkg::addr_t  val_raddr, min_raddr;
  mts_pkg::data_t  val_rdata, min_rdata;
  logic            accept;
  logic            min_push;

  mts_ram #(.WIDTH(mts_pkg::DATA_W), .DEPTH(mts_pkg::STACK_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (in_value),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  mts_ram #(.WIDTH(mts_pkg::DATA_W), .DEPTH(mts_pkg::STACK_DEPTH)) u_min_ram (
    .clk   (clk),
    .we    (min_we),
    .waddr (min_waddr),
    .wdata (in_value),
    .raddr (min_raddr),
    .rdata (min_rdata)
  );

  assign busy      = (state_r == mts_pkg::ST_POP_RD);
  assign accept    = start && !busy;
  assign val_waddr = vp_r[mts_pkg::ADDR_W-1:0];
  assign min_waddr = mp_r[mts_pkg::ADDR_W-1:0];
  assign min_push  = (mp_r == '0) || (in_value <= mtop_r);

  always_comb begin
    state_nxt     = state_r;
    vp_nxt        = vp_r;
    mp_nxt        = mp_r;
    top_nxt       = top_r;
    mtop_nxt      = mtop_r;
    val_we        = 1'b0;
    min_we        = 1'b0;
    val_raddr     = mts_pkg::addr_t'(vp_r - mts_pkg::ptr_t'(2));
    min_raddr     = mts_pkg::addr_t'(mp_r - mts_pkg::ptr_t'(1));
    out_valid_nxt = 1'b0;
    out_ovf_nxt   = 1'b0;
    case (state_r)
      mts_pkg::ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          case (mts_pkg::cmd_t'(in_cmd))
            mts_pkg::CMD_PUSH: begin
              if (vp_r == mts_pkg::FULL_PTR) begin
                out_ovf_nxt = 1'b1;
              end else begin
                val_we  = 1'b1;
                vp_nxt  = vp_r + mts_pkg::ptr_t'(1);
                top_nxt = in_value;
                if (min_push) begin
                  min_we   = 1'b1;
                  mp_nxt   = mp_r + mts_pkg::ptr_t'(1);
                  mtop_nxt = in_value;
                end
              end
            end
            mts_pkg::CMD_POP: begin
              if (vp_r != '0) begin
                vp_nxt = vp_r - mts_pkg::ptr_t'(1);
                if (mp_r != '0 && top_r == mtop_r) begin
                  mp_nxt    = mp_r - mts_pkg::ptr_t'(1);
                  min_raddr = mts_pkg::addr_t'(mp_r - mts_pkg::ptr_t'(2));
                end
                out_valid_nxt = 1'b0;
                state_nxt     = mts_pkg::ST_POP_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      mts_pkg::ST_POP_RD: begin
        top_nxt       = val_rdata;
        mtop_nxt      = min_rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = mts_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mts_pkg::ST_IDLE;
      end
    endcase
    out_top_nxt   = (vp_nxt == '0) ? mts_pkg::NONE_VALUE : top_nxt;
    out_min_nxt   = (vp_nxt == '0 || mp_nxt == '0) ? mts_pkg::NONE_VALUE : mtop_nxt;
    out_empty_nxt = (vp_nxt == '0);
    out_count_nxt = mts_pkg::count_t'(vp_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mts_pkg::ST_IDLE;
      vp_r        <= '0;
      mp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vp_r        <= vp_nxt;
      mp_r        <= mp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r       <= top_nxt;
    mtop_r      <= mtop_nxt;
    out_top_r   <= out_top_nxt;
    out_min_r   <= out_min_nxt;
    out_empty_r <= out_empty_nxt;
    out_count_r <= out_count_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_top_value   = out_top_r;
  assign out_min_value   = out_min_r;
  assign out_is_empty    = out_empty_r;
  assign out_entry_count = out_count_r;
  assign out_overflow    = out_ovf_r;

endmodule
